// ----- rtl/pept_pkg.sv -----
// shared types and constants for the peer entity permission table
package pept_pkg;

    // request codes
    localparam logic [3:0] REQ_BEGIN      = 4'd0;
    localparam logic [3:0] REQ_END        = 4'd1;
    localparam logic [3:0] REQ_CHK_SESS   = 4'd2;
    localparam logic [3:0] REQ_GRANT      = 4'd3;
    localparam logic [3:0] REQ_REVOKE     = 4'd4;
    localparam logic [3:0] REQ_CHK_ENT    = 4'd5;
    localparam logic [3:0] REQ_DROP       = 4'd6;
    localparam logic [3:0] REQ_SRV_GRANT  = 4'd7;
    localparam logic [3:0] REQ_SRV_REVOKE = 4'd8;
    localparam logic [3:0] REQ_SRV_CHK    = 4'd9;
    localparam logic [3:0] REQ_COUNT      = 4'd10;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_SESSION  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DENIED   = 3'd4;

    // datapath commands
    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_LOAD       = 4'd1;  // capture request, clear scans
    localparam logic [3:0] CMD_PEER_SCAN  = 4'd2;  // one peer slot
    localparam logic [3:0] CMD_PEER_ALLOC = 4'd3;  // create / update peer
    localparam logic [3:0] CMD_GRANT_SCAN = 4'd4;  // one grant slot
    localparam logic [3:0] CMD_SRV_SCAN   = 4'd5;  // one server slot
    localparam logic [3:0] CMD_FINISH     = 4'd6;  // apply update, form result

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic [3:0] req;
        logic       ent_zero;
        logic       sess_zero;
        logic       peer_scan_last;
        logic       grant_scan_last;
        logic       srv_scan_last;
    } t_sts;

endpackage

// ----- rtl/pept_ctrl.sv -----
// request sequencer: walks peer, grant and server scans one slot a cycle
module pept_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_res_load,
    input  logic            i_res_free,
    input  pept_pkg::t_sts  i_sts,
    output pept_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PEER  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_GRANT = 3'd3;
    localparam logic [2:0] S_SRV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       needs_alloc, needs_grant;

    // requests that create a peer / look at its grant set
    assign needs_alloc = (i_sts.req == pept_pkg::REQ_BEGIN && !i_sts.sess_zero) ||
                         (i_sts.req == pept_pkg::REQ_GRANT && !i_sts.ent_zero);
    assign needs_grant = (i_sts.req == pept_pkg::REQ_GRANT) ||
                         (i_sts.req == pept_pkg::REQ_REVOKE) ||
                         (i_sts.req == pept_pkg::REQ_CHK_ENT) ||
                         (i_sts.req == pept_pkg::REQ_DROP) ||
                         (i_sts.req == pept_pkg::REQ_COUNT);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res_load = (r_state == S_DONE) && i_res_free;

    // next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = pept_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = pept_pkg::CMD_LOAD;
                    n_state  = S_PEER;
                end
            end
            S_PEER: begin
                o_cmd.op = pept_pkg::CMD_PEER_SCAN;
                if (i_sts.peer_scan_last) begin
                    if (needs_alloc) n_state = S_ALLOC;
                    else if (needs_grant) n_state = S_GRANT;
                    else n_state = S_SRV;
                end
            end
            S_ALLOC: begin
                o_cmd.op = pept_pkg::CMD_PEER_ALLOC;
                n_state  = needs_grant ? S_GRANT : S_SRV;
            end
            S_GRANT: begin
                o_cmd.op = pept_pkg::CMD_GRANT_SCAN;
                if (i_sts.grant_scan_last) n_state = S_SRV;
            end
            S_SRV: begin
                o_cmd.op = pept_pkg::CMD_SRV_SCAN;
                if (i_sts.srv_scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    o_cmd.op = pept_pkg::CMD_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`ifndef SYNTH
    // a result is produced only from the finish state
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> r_state == S_DONE)
        else $error("result load outside done");
    // a new request always starts a peer scan
    a_load_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_PEER)
        else $error("request did not start peer scan");
    // finishing returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |=> r_state == S_IDLE)
        else $error("finish did not return to idle");
`endif

endmodule

// ----- rtl/pept_dpath.sv -----
// tables, slot scans and result formation
module pept_dpath #(
    parameter int PEER_SLOTS      = 16,
    parameter int GRANTS_PER_PEER = 8,
    parameter int SERVER_SLOTS    = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pept_pkg::t_cmd  i_cmd,
    input  logic [3:0]      i_req_type,
    input  logic [31:0]     i_peer_key,
    input  logic [31:0]     i_session_key,
    input  logic [31:0]     i_entity_key,
    output pept_pkg::t_sts  o_sts,
    output logic [2:0]      o_status_code,
    output logic [31:0]     o_detail_value,
    output logic [3:0]      o_entity_count
);

    localparam int PW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int GW = (GRANTS_PER_PEER > 1) ? $clog2(GRANTS_PER_PEER) : 1;
    localparam int SW = (SERVER_SLOTS > 1) ? $clog2(SERVER_SLOTS) : 1;
    localparam int CW = $clog2(GRANTS_PER_PEER + 1);
    localparam int TOTAL_GRANTS = PEER_SLOTS * GRANTS_PER_PEER;
    localparam int AW = $clog2(TOTAL_GRANTS) > 0 ? $clog2(TOTAL_GRANTS) : 1;

    // tables (flip-flop arrays, read at the scan index, or at the found peer slot for
    // sessions; grant ids are a memory read through a register)
    logic [PEER_SLOTS-1:0]      r_peer_valid;
    logic [31:0]                r_peer_ident   [PEER_SLOTS];
    logic [31:0]                r_peer_session [PEER_SLOTS];
    logic [63:0]                r_peer_stamp   [PEER_SLOTS];
    logic [TOTAL_GRANTS-1:0]    r_grant_valid;
    logic [31:0]                r_grant_ident  [TOTAL_GRANTS];
    logic [SERVER_SLOTS-1:0]    r_srv_valid;
    logic [31:0]                r_srv_ident    [SERVER_SLOTS];
    logic [63:0]                r_stamp_cnt;

    // request capture
    logic [3:0]  r_req;
    logic [31:0] r_peer, r_sess, r_ent;

    // scan state
    logic [PW-1:0] r_pidx;
    logic [GW-1:0] r_gidx;
    logic [SW-1:0] r_sidx;
    logic          r_pfound, r_pfree_ok, r_pvict_ok;
    logic [PW-1:0] r_pslot, r_pfree, r_pvict;
    logic          r_gfound, r_gfree_ok, r_gmin_ok;
    logic [GW-1:0] r_gslot, r_gfree, r_gmin;
    logic [31:0]   r_gmin_id;
    logic [CW-1:0] r_gcnt;
    logic          r_sfound, r_sfree_ok, r_smin_ok;
    logic [SW-1:0] r_sslot, r_sfree, r_smin;
    logic [31:0]   r_smin_id;
    logic [63:0]   r_vict_stamp;
    logic [31:0]   r_vict_id;

    // grant scan read stage
    logic          r_gread_done;
    logic          r_grd_hit;
    logic [31:0]   r_grd_id;
    logic [GW-1:0] r_grd_idx;

    logic [AW-1:0] gaddr;
    logic [AW-1:0] gbase;
    logic          g_hit_valid;

    assign gbase = AW'(r_pslot) * AW'(GRANTS_PER_PEER);
    assign gaddr = gbase + AW'(r_gidx);
    assign g_hit_valid = r_pfound && r_grant_valid[gaddr];

    assign o_sts.req             = r_req;
    assign o_sts.ent_zero        = (r_ent == 32'd0);
    assign o_sts.sess_zero       = (r_sess == 32'd0);
    assign o_sts.peer_scan_last  = (r_pidx == PW'(PEER_SLOTS - 1));
    assign o_sts.grant_scan_last = r_gread_done;
    assign o_sts.srv_scan_last   = (r_sidx == SW'(SERVER_SLOTS - 1));

    // control-state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_valid  <= '0;
            r_grant_valid <= '0;
            r_srv_valid   <= '0;
            r_stamp_cnt   <= '0;
        end else begin
            case (i_cmd.op)
                pept_pkg::CMD_PEER_ALLOC: begin
                    r_stamp_cnt <= r_stamp_cnt + 64'd1;
                    if (!r_pfound) begin
                        r_peer_valid[r_pslot] <= 1'b1;
                        for (int i = 0; i < GRANTS_PER_PEER; i++)
                            r_grant_valid[gbase + AW'(i)] <= 1'b0;
                    end
                end
                pept_pkg::CMD_FINISH: begin
                    case (r_req)
                        pept_pkg::REQ_GRANT: begin
                            if (r_ent != 32'd0 && !r_gfound && r_gfree_ok)
                                r_grant_valid[gbase + AW'(r_gfree)] <= 1'b1;
                        end
                        pept_pkg::REQ_REVOKE: begin
                            if (r_pfound && r_gfound)
                                r_grant_valid[gbase + AW'(r_gslot)] <= 1'b0;
                        end
                        pept_pkg::REQ_DROP: begin
                            if (r_pfound) begin
                                r_peer_valid[r_pslot] <= 1'b0;
                                for (int i = 0; i < GRANTS_PER_PEER; i++)
                                    r_grant_valid[gbase + AW'(i)] <= 1'b0;
                            end
                        end
                        pept_pkg::REQ_SRV_GRANT: begin
                            if (r_ent != 32'd0 && !r_sfound && r_sfree_ok)
                                r_srv_valid[r_sfree] <= 1'b1;
                        end
                        pept_pkg::REQ_SRV_REVOKE: begin
                            if (r_sfound) r_srv_valid[r_sslot] <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // payload tables and scan registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pept_pkg::CMD_LOAD: begin
                r_req <= i_req_type;
                r_peer <= i_peer_key;
                r_sess <= i_session_key;
                r_ent <= i_entity_key;
                r_pidx <= '0; r_gidx <= '0; r_sidx <= '0;
                r_pfound <= 1'b0; r_pfree_ok <= 1'b0; r_pvict_ok <= 1'b0;
                r_gfound <= 1'b0; r_gfree_ok <= 1'b0; r_gmin_ok <= 1'b0;
                r_sfound <= 1'b0; r_sfree_ok <= 1'b0; r_smin_ok <= 1'b0;
                r_gcnt <= '0;
                r_gread_done <= 1'b0;
                r_grd_hit <= 1'b0;
            end
            pept_pkg::CMD_PEER_SCAN: begin
                if (r_peer_valid[r_pidx]) begin
                    if (!r_pfound && r_peer_ident[r_pidx] == r_peer) begin
                        r_pfound <= 1'b1;
                        r_pslot  <= r_pidx;
                    end
                    if (!r_pvict_ok || r_peer_stamp[r_pidx] < r_vict_stamp ||
                        (r_peer_stamp[r_pidx] == r_vict_stamp &&
                         r_peer_ident[r_pidx] < r_vict_id)) begin
                        r_pvict_ok   <= 1'b1;
                        r_pvict      <= r_pidx;
                        r_vict_stamp <= r_peer_stamp[r_pidx];
                        r_vict_id    <= r_peer_ident[r_pidx];
                    end
                end else if (!r_pfree_ok) begin
                    r_pfree_ok <= 1'b1;
                    r_pfree    <= r_pidx;
                end
                if (r_pidx == PW'(PEER_SLOTS - 1)) begin
                    // missing peer: point at the slot a create would use
                    if (!r_pfound && !(r_peer_valid[r_pidx] &&
                                       r_peer_ident[r_pidx] == r_peer)) begin
                        if (r_pfree_ok) r_pslot <= r_pfree;
                        else if (!r_peer_valid[r_pidx]) r_pslot <= r_pidx;
                        else if (r_pvict_ok && !(r_peer_stamp[r_pidx] < r_vict_stamp ||
                                 (r_peer_stamp[r_pidx] == r_vict_stamp &&
                                  r_peer_ident[r_pidx] < r_vict_id)))
                            r_pslot <= r_pvict;
                        else r_pslot <= r_pidx;
                    end
                end else begin
                    r_pidx <= r_pidx + PW'(1);
                end
            end
            pept_pkg::CMD_PEER_ALLOC: begin
                r_pfound <= 1'b1;
                r_peer_ident[r_pslot] <= r_peer;
                r_peer_stamp[r_pslot] <= r_stamp_cnt + 64'd1;
                if (r_req == pept_pkg::REQ_BEGIN) r_peer_session[r_pslot] <= r_sess;
                else if (!r_pfound) r_peer_session[r_pslot] <= 32'd0;
            end
            pept_pkg::CMD_GRANT_SCAN: begin
                // read stage: id memory read, count and free slot from the valid bits
                r_grd_id  <= r_grant_ident[gaddr];
                r_grd_idx <= r_gidx;
                r_grd_hit <= g_hit_valid && !r_gread_done;
                if (!r_gread_done) begin
                    if (g_hit_valid) begin
                        r_gcnt <= r_gcnt + CW'(1);
                    end else if (r_pfound && !r_gfree_ok) begin
                        r_gfree_ok <= 1'b1;
                        r_gfree    <= r_gidx;
                    end
                    if (r_gidx != GW'(GRANTS_PER_PEER - 1)) r_gidx <= r_gidx + GW'(1);
                    else r_gread_done <= 1'b1;
                end
                // compare stage: id read in the previous cycle
                if (r_grd_hit) begin
                    if (!r_gfound && r_grd_id == r_ent) begin
                        r_gfound <= 1'b1;
                        r_gslot  <= r_grd_idx;
                    end
                    if (!r_gmin_ok || r_grd_id < r_gmin_id) begin
                        r_gmin_ok <= 1'b1;
                        r_gmin    <= r_grd_idx;
                        r_gmin_id <= r_grd_id;
                    end
                end
            end
            pept_pkg::CMD_SRV_SCAN: begin
                if (r_srv_valid[r_sidx]) begin
                    if (!r_sfound && r_srv_ident[r_sidx] == r_ent) begin
                        r_sfound <= 1'b1;
                        r_sslot  <= r_sidx;
                    end
                    if (!r_smin_ok || r_srv_ident[r_sidx] < r_smin_id) begin
                        r_smin_ok <= 1'b1;
                        r_smin    <= r_sidx;
                        r_smin_id <= r_srv_ident[r_sidx];
                    end
                end else if (!r_sfree_ok) begin
                    r_sfree_ok <= 1'b1;
                    r_sfree    <= r_sidx;
                end
                if (r_sidx != SW'(SERVER_SLOTS - 1)) r_sidx <= r_sidx + SW'(1);
            end
            pept_pkg::CMD_FINISH: begin
                case (r_req)
                    pept_pkg::REQ_END: begin
                        if (r_pfound) r_peer_session[r_pslot] <= 32'd0;
                    end
                    pept_pkg::REQ_GRANT: begin
                        if (r_ent != 32'd0 && !r_gfound) begin
                            if (r_gfree_ok) r_grant_ident[gbase + AW'(r_gfree)] <= r_ent;
                            else if (r_gmin_ok && r_gmin_id < r_ent)
                                r_grant_ident[gbase + AW'(r_gmin)] <= r_ent;
                        end
                    end
                    pept_pkg::REQ_SRV_GRANT: begin
                        if (r_ent != 32'd0 && !r_sfound) begin
                            if (r_sfree_ok) r_srv_ident[r_sfree] <= r_ent;
                            else if (r_smin_ok && r_smin_id < r_ent)
                                r_srv_ident[r_smin] <= r_ent;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // result of the finished request
    always_comb begin
        o_status_code  = pept_pkg::ST_OK;
        o_detail_value = 32'd0;
        o_entity_count = 4'd0;
        case (r_req)
            pept_pkg::REQ_BEGIN: begin
                if (r_sess == 32'd0) o_status_code = pept_pkg::ST_INVALID;
            end
            pept_pkg::REQ_END: ;
            pept_pkg::REQ_CHK_SESS: begin
                if (!r_pfound || r_peer_session[r_pslot] == 32'd0 ||
                    r_peer_session[r_pslot] != r_sess) begin
                    o_status_code  = pept_pkg::ST_SESSION;
                    o_detail_value = r_sess;
                end
            end
            pept_pkg::REQ_GRANT: begin
                if (r_ent == 32'd0) o_status_code = pept_pkg::ST_INVALID;
            end
            pept_pkg::REQ_REVOKE: begin
                if (!r_pfound || !r_gfound) begin
                    o_status_code  = pept_pkg::ST_NOTFOUND;
                    o_detail_value = r_ent;
                end
            end
            pept_pkg::REQ_CHK_ENT: begin
                if (r_ent == 32'd0) o_status_code = pept_pkg::ST_DENIED;
                else if (!r_pfound || !r_gfound) begin
                    o_status_code  = pept_pkg::ST_DENIED;
                    o_detail_value = r_ent;
                end
            end
            pept_pkg::REQ_DROP: ;
            pept_pkg::REQ_SRV_GRANT: begin
                if (r_ent == 32'd0) o_status_code = pept_pkg::ST_INVALID;
            end
            pept_pkg::REQ_SRV_REVOKE: begin
                if (!r_sfound) begin
                    o_status_code  = pept_pkg::ST_NOTFOUND;
                    o_detail_value = r_ent;
                end
            end
            pept_pkg::REQ_SRV_CHK: begin
                if (r_ent == 32'd0 || !r_sfound) begin
                    o_status_code  = pept_pkg::ST_DENIED;
                    o_detail_value = r_ent;
                end
            end
            pept_pkg::REQ_COUNT: begin
                if (r_pfound)
                    o_entity_count = (r_gcnt > CW'(15)) ? 4'd15 : 4'(r_gcnt);
            end
            default: o_status_code = pept_pkg::ST_INVALID;
        endcase
    end

`ifndef SYNTH
    // a grant scan never counts more than the set holds
    a_gcnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == pept_pkg::CMD_FINISH |-> r_gcnt <= CW'(GRANTS_PER_PEER))
        else $error("grant count overflow");
    // a found grant implies a found peer
    a_gfound_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pept_pkg::CMD_FINISH && r_gfound) |-> r_pfound)
        else $error("grant found without peer");
    // peer creation always bumps the stamp counter
    a_stamp_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == pept_pkg::CMD_PEER_ALLOC |=> r_stamp_cnt == $past(r_stamp_cnt) + 64'd1)
        else $error("stamp not advanced");
`endif

endmodule

// ----- rtl/peer_entity_permission_table_core.sv -----
// top level of the peer entity permission table
//
//  channel  | dir | handshake          | contents
//  s_axis   | in  | tvalid / tready    | tdata: req_type, peer_key, session_key, entity_key
//  m_axis   | out | tvalid / tready    | tdata: status_code, detail_value, entity_count
//
// one request at a time, its cost set by the slot-by-slot scans of the peer,
// grant and server tables, plus a create step for begin/grant requests; the grant
// scan serves grant-set requests (the grant id memory is read through a register,
// so each compare uses the id read for the previous index).
// a result register lets the next request be taken while a result waits.
// reset (synchronous, active low) clears all valid marks at once and the stamp.
module peer_entity_permission_table_core #(
    parameter int PEER_SLOTS      = 16,
    parameter int GRANTS_PER_PEER = 8,
    parameter int SERVER_SLOTS    = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[3:0], peer_key[35:4], session_key[67:36], entity_key[99:68], zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status_code[2:0], detail_value[34:3], entity_count[38:35], zero pad
    output logic [39:0]  m_axis_tdata
);

    pept_pkg::t_cmd cmd;
    pept_pkg::t_sts sts;
    logic           res_load, res_free;
    logic [2:0]     status_code;
    logic [31:0]    detail_value;
    logic [3:0]     entity_count;
    logic           r_out_valid;
    logic [38:0]    r_out_data;

    assign res_free = !r_out_valid || m_axis_tready;

    pept_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_res_load (res_load),
        .i_res_free (res_free),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pept_dpath #(
        .PEER_SLOTS      (PEER_SLOTS),
        .GRANTS_PER_PEER (GRANTS_PER_PEER),
        .SERVER_SLOTS    (SERVER_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (s_axis_tdata[3:0]),
        .i_peer_key     (s_axis_tdata[35:4]),
        .i_session_key  (s_axis_tdata[67:36]),
        .i_entity_key   (s_axis_tdata[99:68]),
        .o_sts          (sts),
        .o_status_code  (status_code),
        .o_detail_value (detail_value),
        .o_entity_count (entity_count)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) r_out_data <= {entity_count, detail_value, status_code};
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};

endmodule
